FILE: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, command codes and the word types that pass between the
// front classifier, the command and result queues and the back executor.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int TEXT_ROWS_DEF      = 25;
  localparam int TEXT_COLUMNS_DEF   = 80;
  localparam int CMD_QUEUE_DEPTH    = 2;
  localparam int RESULT_QUEUE_DEPTH = 2;

  localparam logic [7:0] BLANK_CHAR     = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR   = 8'd10;
  localparam logic [7:0] COLOR_AT_RESET = 8'h05;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  row_now;
    logic [6:0]  column_now;
    logic        scrolled;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcw_fifo.sv
// ----------------------------------------------------------------------------
// Text console writer word queue
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [WIDTH-1:0] data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + NW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcw_front.sv
// ----------------------------------------------------------------------------
// Text console writer front end
// Classifies an incoming item into a command for the back end: newline versus
// printable put, clear, in-range read, or no operation.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front #(
  parameter int TEXT_ROWS    = tcw_pkg::TEXT_ROWS_DEF,
  parameter int TEXT_COLUMNS = tcw_pkg::TEXT_COLUMNS_DEF
) (
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [4:0] read_row_i,
  input  wire logic [6:0] read_col_i,
  output tcw_pkg::cmd_t   cmd_o
);

  logic in_range;

  assign in_range = (32'(read_row_i) < TEXT_ROWS) && (32'(read_col_i) < TEXT_COLUMNS);

  always_comb begin
    cmd_o.char_code = char_code_i;
    cmd_o.read_row  = read_row_i;
    cmd_o.read_col  = read_col_i;
    case (kind_i)
      tcw_pkg::KIND_PUT: begin
        cmd_o.op = (char_code_i == tcw_pkg::NEWLINE_CHAR) ? tcw_pkg::OP_NEWLINE
                                                          : tcw_pkg::OP_PUT;
      end
      tcw_pkg::KIND_CLEAR: begin
        cmd_o.op = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::KIND_READ: begin
        cmd_o.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
      end
      default: begin
        cmd_o.op = tcw_pkg::OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcw_back.sv
// ----------------------------------------------------------------------------
// Text console writer back end
// Holds the screen memory, the cursor and the circular top-row offset, and
// runs commands one at a time: cell writes, reads and blanking sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back #(
  parameter int TEXT_ROWS    = tcw_pkg::TEXT_ROWS_DEF,
  parameter int TEXT_COLUMNS = tcw_pkg::TEXT_COLUMNS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    text_color_i,
  input  wire logic          cmd_empty_i,
  input  wire tcw_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output tcw_pkg::res_t      res_o
);

  localparam int RW    = $clog2(TEXT_ROWS);
  localparam int CW    = $clog2(TEXT_COLUMNS);
  localparam int CELLS = TEXT_ROWS * TEXT_COLUMNS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [1:0] S_INIT   = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SWEEP  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [15:0]   screen_q [CELLS];
  logic [15:0]   rdata_q;

  logic [1:0]    state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] top_q, top_d;
  logic [AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [AW-1:0] sweep_last_q, sweep_last_d;
  logic [15:0]   sweep_data_q, sweep_data_d;
  logic          scrolled_q, scrolled_d;
  logic          from_mem_q, from_mem_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;
  logic [AW-1:0] cursor_addr, read_addr, top_base;
  logic [15:0]   text_blank;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r, input logic [RW-1:0] t);
    logic [RW:0] sum;
    sum = {1'b0, r} + {1'b0, t};
    if (sum >= (RW + 1)'(TEXT_ROWS)) begin
      sum = sum - (RW + 1)'(TEXT_ROWS);
    end
    return sum[RW-1:0];
  endfunction

  assign text_blank  = {text_color_i, tcw_pkg::BLANK_CHAR};
  assign cursor_addr = AW'(phys_row(row_q, top_q)) * AW'(TEXT_COLUMNS) + AW'(col_q);
  assign read_addr   = AW'(phys_row(RW'(cmd_i.read_row), top_q)) * AW'(TEXT_COLUMNS)
                     + AW'(CW'(cmd_i.read_col));
  assign top_base    = AW'(top_q) * AW'(TEXT_COLUMNS);

  assign res_push_o       = (state_q == S_RESULT) && !res_full_i;
  assign res_o.cell_value = from_mem_q ? rdata_q : 16'd0;
  assign res_o.row_now    = 5'(row_q);
  assign res_o.column_now = 7'(col_q);
  assign res_o.scrolled   = scrolled_q;

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    top_d        = top_q;
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    sweep_data_d = sweep_data_q;
    scrolled_d   = scrolled_q;
    from_mem_d   = from_mem_q;
    cmd_pop_o    = 1'b0;
    we           = 1'b0;
    waddr        = sweep_addr_q;
    wdata        = sweep_data_q;
    re           = 1'b0;
    raddr        = read_addr;

    case (state_q)
      S_INIT, S_SWEEP: begin
        we           = 1'b1;
        sweep_addr_d = sweep_addr_q + AW'(1);
        if (sweep_addr_q == sweep_last_q) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_RESULT;
        end
      end
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o  = 1'b1;
          scrolled_d = 1'b0;
          from_mem_d = 1'b0;
          state_d    = S_RESULT;
          case (cmd_i.op)
            tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE: begin
              if (cmd_i.op == tcw_pkg::OP_PUT) begin
                we    = 1'b1;
                waddr = cursor_addr;
                wdata = {text_color_i, cmd_i.char_code};
              end
              if (cmd_i.op == tcw_pkg::OP_PUT && col_q != CW'(TEXT_COLUMNS - 1)) begin
                col_d = col_q + CW'(1);
              end else begin
                col_d = '0;
                if (row_q == RW'(TEXT_ROWS - 1)) begin
                  top_d        = (top_q == RW'(TEXT_ROWS - 1)) ? '0 : top_q + RW'(1);
                  sweep_addr_d = top_base;
                  sweep_last_d = top_base + AW'(TEXT_COLUMNS - 1);
                  sweep_data_d = text_blank;
                  scrolled_d   = 1'b1;
                  state_d      = S_SWEEP;
                end else begin
                  row_d = row_q + RW'(1);
                end
              end
            end
            tcw_pkg::OP_CLEAR: begin
              row_d        = '0;
              col_d        = '0;
              sweep_addr_d = '0;
              sweep_last_d = AW'(CELLS - 1);
              sweep_data_d = text_blank;
              state_d      = S_SWEEP;
            end
            tcw_pkg::OP_READ: begin
              re         = 1'b1;
              from_mem_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_RESULT: begin
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      row_q        <= '0;
      col_q        <= '0;
      top_q        <= '0;
      sweep_addr_q <= '0;
      sweep_last_q <= AW'(CELLS - 1);
      sweep_data_q <= {tcw_pkg::COLOR_AT_RESET, tcw_pkg::BLANK_CHAR};
      scrolled_q   <= 1'b0;
      from_mem_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      top_q        <= top_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
      sweep_data_q <= sweep_data_d;
      scrolled_q   <= scrolled_d;
      from_mem_q   <= from_mem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      screen_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= screen_q[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// A put, newline or read result passes through the command queue, the back
// end's result state and the result queue before it appears. The back end runs
// one item at a time; a scroll also blanks one row of the screen memory, a clear
// blanks every cell. After reset the back end sweeps all TEXT_ROWS * TEXT_COLUMNS
// cells blank (2000 cells by default) before it runs queued items.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int TEXT_ROWS    = tcw_pkg::TEXT_ROWS_DEF,
  parameter int TEXT_COLUMNS = tcw_pkg::TEXT_COLUMNS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [4:0]  read_row_i,
  input  wire logic [6:0]  read_col_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      cell_value_o,
  output logic [4:0]       row_now_o,
  output logic [6:0]       column_now_o,
  output logic             scrolled_o
);

  localparam int CMD_W = $bits(tcw_pkg::cmd_t);
  localparam int RES_W = $bits(tcw_pkg::res_t);

  logic [7:0]       text_color_q;
  tcw_pkg::cmd_t    front_cmd;
  logic [CMD_W-1:0] cmd_bits;
  logic             cmd_empty, cmd_pop;
  tcw_pkg::res_t    back_res, out_res;
  logic [RES_W-1:0] res_bits;
  logic             res_full, res_push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tcw_pkg::COLOR_AT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      text_color_q <= cfg_data_i;
    end
  end

  tcw_front #(
    .TEXT_ROWS   (TEXT_ROWS),
    .TEXT_COLUMNS(TEXT_COLUMNS)
  ) u_front (
    .kind_i     (kind_i),
    .char_code_i(char_code_i),
    .read_row_i (read_row_i),
    .read_col_i (read_col_i),
    .cmd_o      (front_cmd)
  );

  tcw_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(tcw_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .data_i (front_cmd),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .data_o (cmd_bits)
  );

  tcw_back #(
    .TEXT_ROWS   (TEXT_ROWS),
    .TEXT_COLUMNS(TEXT_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_color_i(text_color_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (tcw_pkg::cmd_t'(cmd_bits)),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  tcw_fifo #(
    .WIDTH(RES_W),
    .DEPTH(tcw_pkg::RESULT_QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .full_o (res_full),
    .data_i (back_res),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (res_bits)
  );

  assign out_res      = tcw_pkg::res_t'(res_bits);
  assign cell_value_o = out_res.cell_value;
  assign row_now_o    = out_res.row_now;
  assign column_now_o = out_res.column_now;
  assign scrolled_o   = out_res.scrolled;

  a_res_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("Result pushed into a full result queue.");

  a_cmd_pop_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("Command popped from an empty command queue.");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((TEXT_ROWS > 32) || (32'(row_now_o) < TEXT_ROWS))
            && (32'(column_now_o) < TEXT_COLUMNS))
    else $error("Reported cursor lies outside the screen.");

  a_scroll_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && scrolled_o) |-> (column_now_o == 7'd0)
                            && ((TEXT_ROWS > 32) || (32'(row_now_o) == TEXT_ROWS - 1)))
    else $error("Scroll result does not leave the cursor at the start of the last row.");

endmodule

`default_nettype wire
